@@ rtl/slt_pkg.sv @@
`timescale 1ns / 1ps

package slt_pkg;

   // Token count saturation; the result fields are 8 bits wide, so the cap is 255 at most.
   localparam int MAX_TOKENS = 255;
   localparam int CAP_INT    = (MAX_TOKENS > 255) ? 255 : MAX_TOKENS;
   localparam logic [7:0] TOKEN_CAP = 8'(CAP_INT);

   // Queue between front and back end; the depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_PIPE   = 8'h7C;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_BLANK,
      CLS_SQUOTE,
      CLS_DQUOTE,
      CLS_LT,
      CLS_GT,
      CLS_PIPE
   } char_class_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_WORD = 3'd1,
      MODE_SQ   = 3'd2,
      MODE_DQ   = 3'd3,
      MODE_LT   = 3'd4,
      MODE_GT   = 3'd5,
      MODE_OP   = 3'd6
   } lex_mode_type;

   typedef struct packed {
      char_class_type cls;
      logic           last;
   } queue_entry_type;

   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type cls;
      cls = CLS_OTHER;
      if (ch == CHAR_SPACE || ch == CHAR_TAB) begin
         cls = CLS_BLANK;
      end else if (ch == CHAR_SQUOTE) begin
         cls = CLS_SQUOTE;
      end else if (ch == CHAR_DQUOTE) begin
         cls = CLS_DQUOTE;
      end else if (ch == CHAR_LT) begin
         cls = CLS_LT;
      end else if (ch == CHAR_GT) begin
         cls = CLS_GT;
      end else if (ch == CHAR_PIPE) begin
         cls = CLS_PIPE;
      end
      return cls;
   endfunction

endpackage

@@ rtl/slt_front.sv @@
`timescale 1ns / 1ps

module slt_front
   import slt_pkg::*;
(
   input  logic            req_tvalid,
   input  logic [7:0]      req_tdata,
   input  logic            req_tlast,
   input  logic            queue_full,
   output logic            req_tready,
   output logic            push,
   output queue_entry_type push_entry
);

   assign req_tready       = !queue_full;
   assign push             = req_tvalid && !queue_full;
   assign push_entry.cls   = classify(req_tdata);
   assign push_entry.last  = req_tlast;

endmodule

@@ rtl/slt_queue.sv @@
`timescale 1ns / 1ps

module slt_queue
   import slt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output queue_entry_type head
);

   queue_entry_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/slt_back.sv @@
`timescale 1ns / 1ps

module slt_back
   import slt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  queue_entry_type head,
   output logic            pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [23:0]     rsp_tdata,
   output logic            rsp_tlast
);

   lex_mode_type mode_ff, mode_in, mode_next;
   logic [7:0]   count_ff, count_in, count_next;
   logic         member, start;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]  rsp_tdata_ff, rsp_tdata_in;
   logic         rsp_tlast_ff;
   logic [7:0]   token_number, token_total;
   logic         open_quote;

   // Output register frees up when empty or being drained this cycle.
   assign pop = head_valid && (!rsp_tvalid_ff || rsp_tready);

   // Lexer next state
   always_comb begin
      mode_next = mode_ff;
      unique case (mode_ff)
         MODE_SQ: begin
            mode_next = (head.cls == CLS_SQUOTE) ? MODE_WORD : MODE_SQ;
         end
         MODE_DQ: begin
            mode_next = (head.cls == CLS_DQUOTE) ? MODE_WORD : MODE_DQ;
         end
         default: begin
            if ((mode_ff == MODE_LT && head.cls == CLS_LT) ||
                (mode_ff == MODE_GT && head.cls == CLS_GT)) begin
               mode_next = MODE_OP;
            end else begin
               case (head.cls)
                  CLS_BLANK:  mode_next = MODE_IDLE;
                  CLS_LT:     mode_next = MODE_LT;
                  CLS_GT:     mode_next = MODE_GT;
                  CLS_PIPE:   mode_next = MODE_OP;
                  CLS_SQUOTE: mode_next = MODE_SQ;
                  CLS_DQUOTE: mode_next = MODE_DQ;
                  default:    mode_next = MODE_WORD;
               endcase
            end
         end
      endcase
   end

   // Lexer outputs: membership and token start
   always_comb begin
      member = 1'b1;
      start  = 1'b0;
      unique case (mode_ff)
         MODE_SQ, MODE_DQ: begin
            member = 1'b1;
         end
         default: begin
            if ((mode_ff == MODE_LT && head.cls == CLS_LT) ||
                (mode_ff == MODE_GT && head.cls == CLS_GT)) begin
               start = 1'b0;
            end else if (head.cls == CLS_BLANK) begin
               member = 1'b0;
            end else if (head.cls inside {CLS_LT, CLS_GT, CLS_PIPE}) begin
               start = 1'b1;
            end else begin
               start = (mode_ff != MODE_WORD);
            end
         end
      endcase
   end

   always_comb begin
      count_next   = (start && count_ff < TOKEN_CAP) ? count_ff + 8'd1 : count_ff;
      token_number = (member && count_next != 8'd0) ? count_next - 8'd1 : 8'd0;
      token_total  = head.last ? count_next : 8'd0;
      open_quote   = head.last && (mode_next == MODE_SQ || mode_next == MODE_DQ);

      mode_in  = mode_ff;
      count_in = count_ff;
      if (pop) begin
         mode_in  = head.last ? MODE_IDLE : mode_next;
         count_in = head.last ? 8'd0 : count_next;
      end

      rsp_tvalid_in = pop || (rsp_tvalid_ff && !rsp_tready);
      rsp_tdata_in  = {5'd0, open_quote, token_total, token_number, start, member};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         count_ff      <= 8'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= head.last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

@@ rtl/shell_line_tokenizer.sv @@
`timescale 1ns / 1ps

// Shell command line tokenizer. Bytes of a command line stream in on the req_ channel, one
// transaction per byte, with req_tlast on the final byte; every byte yields exactly one
// result transaction on the rsp_ channel, in order. Blanks (space, tab) outside quotes are
// dropped and separate tokens; single and double quotes may open anywhere in a word and keep
// blanks and operator bytes inside; |, < and > are tokens of their own, and << and >> pair
// into one. Each result says whether the byte belongs to a token, whether it starts one, and
// the 0-based token index (saturating at MAX_TOKENS-1). The result for the last byte also
// carries the line's token total (saturating at MAX_TOKENS) and an unclosed-quote flag, and
// the lexer then starts over for the next line. Throughput is one byte per clock while the
// output is not stalled, set by the lexer state update in the back end; a byte's result is
// presented on the clock after the one in which the back end takes it from the queue. A
// four-entry queue decouples the input from output backpressure, so the input stays
// ready for up to four more bytes while a result waits to be taken; after that req_tready
// drops until the output drains.

module shell_line_tokenizer
   import slt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] in_token, [1] starts_token, [9:2] token_number,
                                    // [17:10] token_total, [18] open_quote, [23:19] zero
   output logic        rsp_tlast    // line_end
);

   logic            push, pop;
   logic            queue_full, queue_not_empty;
   queue_entry_type push_entry, head;

   // Front end: byte classification, accepts while the queue has room
   slt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .req_tready (req_tready),
      .push       (push),
      .push_entry (push_entry)
   );

   // Classified bytes waiting for the lexer
   slt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   // Back end: lexer state, token counter and registered result
   slt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/slt_checker.sv @@
`timescale 1ns / 1ps

module slt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Queue is empty after reset, so the input is ready.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

   // Line totals and quote flag only show on the line's last byte.
   a_total_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[18:10] == 9'd0)
      else $error("line summary outside line end");

   // A token start is always a member byte, and a dropped blank has index zero.
   a_start_member: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[0]) &&
                     (rsp_tdata[0] || rsp_tdata[9:2] == 8'd0))
      else $error("inconsistent token flags");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the shell line tokenizer. One transaction on req_ carries one byte
// of a command line; one transaction on rsp_ carries the marks for that byte.

module testbench;
   import slt_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 400000;   // several times the slowest legal run
   localparam int DRAIN_CYCLES = 16;

   // Marks expected for one byte, unpacked from rsp_tdata / rsp_tlast.
   typedef struct packed {
      logic       in_token;
      logic       starts_token;
      logic [7:0] token_number;
      logic       line_end;
      logic [7:0] token_total;
      logic       open_quote;
   } token_marks_type;

   // Lexer predictor plus the queue of marks still owed by the block.
   class token_scoreboard;
      lex_mode_type    lex_mode;
      logic [7:0]      tokens_seen;
      token_marks_type owed_marks[$];
      int              errors;

      function new();
         lex_mode    = MODE_IDLE;
         tokens_seen = '0;
         errors      = 0;
      endfunction

      // Accepted byte: advance the lexer and queue the marks it must produce.
      function void note_byte(input logic [7:0] ch, input logic last);
         lex_mode_type    nxt;
         logic            member;
         logic            start;
         token_marks_type marks;
         nxt    = lex_mode;
         member = 1'b1;
         start  = 1'b0;
         if (nxt > MODE_OP) nxt = MODE_IDLE;
         if (nxt == MODE_SQ || nxt == MODE_DQ) begin
            // inside quotes everything is word text until the matching quote
            if ((nxt == MODE_SQ && ch == CHAR_SQUOTE) || (nxt == MODE_DQ && ch == CHAR_DQUOTE))
               nxt = MODE_WORD;
         end else if ((nxt == MODE_LT && ch == CHAR_LT) || (nxt == MODE_GT && ch == CHAR_GT)) begin
            nxt = MODE_OP;    // << or >> pairs into the open token
         end else if (ch == CHAR_SPACE || ch == CHAR_TAB) begin
            member = 1'b0;
            nxt    = MODE_IDLE;
         end else if (ch == CHAR_PIPE || ch == CHAR_LT || ch == CHAR_GT) begin
            start = 1'b1;
            if (ch == CHAR_LT)      nxt = MODE_LT;
            else if (ch == CHAR_GT) nxt = MODE_GT;
            else                    nxt = MODE_OP;
         end else begin
            if (nxt != MODE_WORD) start = 1'b1;
            if (ch == CHAR_SQUOTE)      nxt = MODE_SQ;
            else if (ch == CHAR_DQUOTE) nxt = MODE_DQ;
            else                        nxt = MODE_WORD;
         end
         if (start && tokens_seen < TOKEN_CAP) tokens_seen++;

         marks.in_token     = member;
         marks.starts_token = start;
         marks.token_number = (member && tokens_seen != 0) ? tokens_seen - 8'd1 : 8'd0;
         marks.line_end     = last;
         marks.token_total  = last ? tokens_seen : 8'd0;
         marks.open_quote   = last && (nxt == MODE_SQ || nxt == MODE_DQ);
         owed_marks.push_back(marks);

         if (last) begin
            nxt         = MODE_IDLE;
            tokens_seen = '0;
         end
         lex_mode = nxt;
      endfunction

      function void compare_field(input string field, input int want, input int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      // Accepted result: compare against the oldest owed marks.
      function void check_result(input logic [23:0] data, input logic line_end);
         token_marks_type want;
         if (owed_marks.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual data %h last %b",
                     $time, data, line_end);
            return;
         end
         want = owed_marks.pop_front();
         compare_field("in_token",     want.in_token,     data[0]);
         compare_field("starts_token", want.starts_token, data[1]);
         compare_field("token_number", want.token_number, data[9:2]);
         compare_field("token_total",  want.token_total,  data[17:10]);
         compare_field("open_quote",   want.open_quote,   data[18]);
         compare_field("line_end",     want.line_end,     line_end);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [7:0] ch
   logic        req_tlast  = 1'b0;  // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [0] in_token, [1] starts_token, [9:2] token_number,
                                    // [17:10] token_total, [18] open_quote, [23:19] zero
   logic        rsp_tlast;          // line_end

   token_scoreboard marks_board = new();

   int          cycle_count  = 0;
   int          burst_left   = 0;
   int          stall_left   = 0;
   logic        stall_ready  = 1'b1;
   logic        stall_choppy = 1'b0;
   logic [7:0]  line_buf[$];

   shell_line_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver backpressure: ready and stalled runs in random order; some ready runs are
   // choppy (coin flip each cycle), long ready runs give stretches with no stall at all.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_ready  = ($urandom_range(0, 2) != 0);
         stall_left   = stall_ready ? $urandom_range(1, 40) : $urandom_range(1, 8);
         stall_choppy = ($urandom_range(0, 3) == 0);
      end
      stall_left--;
      rsp_tready <= stall_ready && !(stall_choppy && $urandom_range(0, 1) == 1);
   end

   // Result side: every transaction on rsp_ goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) marks_board.check_result(rsp_tdata, rsp_tlast);
   end

   // One byte as one req_ transaction. The sender runs in bursts with idle gaps between
   // them; a gap of zero keeps tvalid high straight into the next burst.
   task automatic send_byte(input logic [7:0] ch, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 5);
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      marks_board.note_byte(ch, last);
      burst_left--;
   endtask

   task automatic send_text(input string text, input logic ends_line);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], ends_line && i == text.len() - 1);
   endtask

   task automatic send_line_buf();
      foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
   endtask

   function automatic logic [7:0] pick_special();
      case ($urandom_range(0, 6))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_SQUOTE;
         3:       return CHAR_DQUOTE;
         4:       return CHAR_LT;
         5:       return CHAR_GT;
         default: return CHAR_PIPE;
      endcase
   endfunction

   // Any byte that is plain word text (all 8 bits vary).
   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_SQUOTE || c == CHAR_DQUOTE ||
             c == CHAR_LT || c == CHAR_GT || c == CHAR_PIPE);
      return c;
   endfunction

   function automatic void add_blanks(input int lo, input int hi);
      repeat ($urandom_range(lo, hi))
         line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endfunction

   // Word with optional quoted pieces mid-word; quoted text may hold blanks and operators.
   function automatic void add_word(input logic leave_open);
      logic [7:0] q;
      int         pieces;
      pieces = $urandom_range(1, 5);
      for (int p = 0; p < pieces; p++) begin
         if ($urandom_range(0, 4) == 0 || (leave_open && p == pieces - 1)) begin
            q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
            line_buf.push_back(q);
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(0, 1)) line_buf.push_back(pick_plain());
               else begin
                  // the other quote kind is plain text in here
                  line_buf.push_back(pick_special());
                  if (line_buf[$] == q) line_buf[$] = CHAR_PIPE;
               end
            end
            if (!(leave_open && p == pieces - 1)) line_buf.push_back(q);
         end else begin
            line_buf.push_back(pick_plain());
         end
      end
   endfunction

   function automatic void add_operator();
      case ($urandom_range(0, 8))
         0: line_buf = {line_buf, CHAR_PIPE};
         1: line_buf = {line_buf, CHAR_LT};
         2: line_buf = {line_buf, CHAR_GT};
         3: line_buf = {line_buf, CHAR_LT, CHAR_LT};
         4: line_buf = {line_buf, CHAR_GT, CHAR_GT};
         5: line_buf = {line_buf, CHAR_LT, CHAR_GT};
         6: line_buf = {line_buf, CHAR_GT, CHAR_LT};
         7: line_buf = {line_buf, CHAR_LT, CHAR_LT, CHAR_LT};
         default: line_buf = {line_buf, CHAR_PIPE, CHAR_GT, CHAR_GT};
      endcase
   endfunction

   // Mostly well-formed command lines with random content, some unterminated quotes,
   // and a share of raw noise lines.
   function automatic void build_random_line();
      int   kind;
      int   tokens;
      logic broken;
      line_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 12))
            line_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_special());
      end else begin
         tokens = $urandom_range(1, 8);
         broken = ($urandom_range(0, 9) == 0);
         add_blanks(0, 2);
         for (int t = 0; t < tokens; t++) begin
            if ($urandom_range(0, 9) < 6) add_word(broken && t == tokens - 1);
            else                          add_operator();
            if (t != tokens - 1) add_blanks($urandom_range(0, 9) < 7 ? 1 : 0, 3);
         end
         if (!broken) add_blanks(0, 2);
      end
   endfunction

   // More tokens than the counter holds, so the count and index must saturate.
   function automatic void build_overflow_line();
      line_buf.delete();
      repeat (int'(TOKEN_CAP) + $urandom_range(1, 12)) begin
         if ($urandom_range(0, 1)) line_buf.push_back(CHAR_PIPE);
         else line_buf = {line_buf, pick_plain(), CHAR_SPACE};
      end
      if ($urandom_range(0, 1)) add_word(1'b0);
   endfunction

   initial begin
      int random_sent;
      int lines_sent;
      random_sent = 0;
      lines_sent  = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: byte zero as word text, quotes opened mid-word holding a blank and an
      // operator, <<< splitting after the pair, >>, unpaired <>, a lone pipe.
      send_byte(8'h00, 1'b0);
      send_text("x'a |'\"b\" <<< >> <> |", 1'b1);
      // Line ending inside a double quote, then a line of a single blank.
      send_text("\t\"a", 1'b1);
      send_text(" ", 1'b1);

      while (random_sent < RANDOM_ITEMS) begin
         if (lines_sent == 8 || lines_sent == 20) build_overflow_line();
         else                                     build_random_line();
         send_line_buf();
         random_sent += line_buf.size();
         lines_sent++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (marks_board.owed_marks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (marks_board.errors == 0 && marks_board.owed_marks.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
